// ===== rtl/bfa_pkg.sv =====
// Shared types and constants for the bitmap frame allocator.
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int PAGE_BYTES = 4096;
  localparam int MAP_BYTES  = (MAX_FRAMES + 7) / 8;

  localparam int FRAME_W    = 12;
  localparam int LEN_W      = 13;
  localparam int ADDR_W     = 24;
  localparam int STATUS_W   = 2;
  localparam int BYTE_IDX_W = $clog2(MAP_BYTES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  localparam logic [LEN_W-1:0]      PAGES_RESET  = LEN_W'(MAX_FRAMES);
  localparam logic [BYTE_IDX_W-1:0] LAST_MAP_IDX = BYTE_IDX_W'(MAP_BYTES - 1);
  localparam logic [7:0]            FULL_BYTE    = 8'hFF;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OOM   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  localparam logic ACTION_ALLOC = 1'b0;
  localparam logic ACTION_MARK  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [FRAME_W-1:0] start_frame;
    logic [LEN_W-1:0]   run_length;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   frame_address;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_MARK_INIT,
    S_MARK_RD,
    S_MARK_WR,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic                clr_step;
    logic                req_load;
    logic                scan_start;
    logic                scan_step;
    logic                base_from_start;
    logic                mark_init;
    logic                mark_rd;
    logic                mark_wr;
    logic                res_set;
    logic [STATUS_W-1:0] res_code;
    logic                res_use_base;
    logic                out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic action;
    logic len_zero;
    logic mark_oob;
    logic alloc_none;
    logic scan_hit;
    logic scan_fail;
    logic mark_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== rtl/bfa_ctrl.sv =====
// Controller state machine of the bitmap frame allocator.
`timescale 1ns / 1ps

module bfa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  bfa_pkg::dp_stat_t stat,
  output logic             in_stall,
  output bfa_pkg::dp_cmd_t  cmd
);
  import bfa_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.action == ACTION_MARK) begin
          if (stat.mark_oob || stat.len_zero) state_nxt = S_DONE;
          else state_nxt = S_MARK_INIT;
        end else begin
          if (stat.alloc_none || stat.len_zero) state_nxt = S_DONE;
          else state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_hit) state_nxt = S_MARK_INIT;
        else if (stat.scan_fail) state_nxt = S_DONE;
      end
      S_MARK_INIT: state_nxt = S_MARK_RD;
      S_MARK_RD:   state_nxt = S_MARK_WR;
      S_MARK_WR: begin
        if (stat.mark_last) state_nxt = S_DONE;
        else state_nxt = S_MARK_RD;
      end
      S_DONE: begin
        if (!stat.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_stall     = 1'b0;
        cmd.req_load = in_valid;
      end
      S_DECIDE: begin
        cmd.res_set = 1'b1;
        if (stat.action == ACTION_MARK) begin
          cmd.res_code        = stat.mark_oob ? STATUS_RANGE : STATUS_OK;
          cmd.base_from_start = 1'b1;
        end else begin
          cmd.res_code   = stat.alloc_none ? STATUS_OOM : STATUS_OK;
          cmd.scan_start = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit) begin
          cmd.res_set      = 1'b1;
          cmd.res_code     = STATUS_OK;
          cmd.res_use_base = 1'b1;
        end else if (stat.scan_fail) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = STATUS_OOM;
        end
      end
      S_MARK_INIT: cmd.mark_init = 1'b1;
      S_MARK_RD:   cmd.mark_rd   = 1'b1;
      S_MARK_WR:   cmd.mark_wr   = 1'b1;
      S_DONE:      cmd.out_load  = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== rtl/bfa_datapath.sv =====
// Datapath of the bitmap frame allocator: bitmap memory, scan and mark logic, result register.
`timescale 1ns / 1ps

module bfa_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [bfa_pkg::LEN_W-1:0] cfg_wr_data,
  input  bfa_pkg::in_item_t         in_data,
  input  logic                     out_stall,
  output logic                     out_valid,
  output bfa_pkg::out_item_t        out_data,
  input  bfa_pkg::dp_cmd_t          cmd,
  output bfa_pkg::dp_stat_t         stat
);
  import bfa_pkg::*;

  logic [7:0] map_mem [MAP_BYTES];
  logic [7:0] rdata_r;

  logic [LEN_W-1:0]      pages_r;
  logic [LEN_W-1:0]      limit;
  in_item_t              req_r;
  logic [BYTE_IDX_W-1:0] addr_r;
  logic [BYTE_IDX_W-1:0] daddr_r;
  logic                  dv_r;
  logic                  issue_done_r;
  logic [LEN_W-1:0]      cnt_r;
  logic [FRAME_W-1:0]    base_r;
  logic [STATUS_W-1:0]   res_code_r;
  logic                  res_use_base_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic [BYTE_IDX_W-1:0] scan_last_byte;
  logic                  issue;
  logic [LEN_W-1:0]      cnt_v;
  logic                  hit_v;
  logic [FRAME_W-1:0]    base_v;
  logic [LEN_W-1:0]      mark_last_frame;
  logic [BYTE_IDX_W-1:0] mark_last_byte;
  logic [2:0]            lo_bit;
  logic [2:0]            hi_bit;
  logic [7:0]            mark_mask;
  logic                  wr_en;
  logic [7:0]            wr_data;
  logic                  rd_en;
  logic [LEN_W:0]        mark_end;

  // Page count saturates at the bitmap capacity.
  assign limit = (pages_r > PAGES_RESET) ? PAGES_RESET : pages_r;

  assign scan_last_byte = BYTE_IDX_W'((limit - LEN_W'(1)) >> 3);
  assign issue          = cmd.scan_step && !issue_done_r;

  always_comb begin
    logic [FRAME_W-1:0] frame_v;
    cnt_v  = cnt_r;
    hit_v  = 1'b0;
    base_v = '0;
    for (int b = 0; b < 8; b++) begin
      frame_v = {daddr_r, 3'(b)};
      if (!hit_v && ({1'b0, frame_v} < limit)) begin
        if (rdata_r[b]) begin
          cnt_v = '0;
        end else begin
          cnt_v = cnt_v + LEN_W'(1);
          if (cnt_v == req_r.run_length) begin
            hit_v  = 1'b1;
            base_v = FRAME_W'({1'b0, frame_v} + LEN_W'(1) - req_r.run_length);
          end
        end
      end
    end
  end

  assign mark_last_frame = {1'b0, base_r} + req_r.run_length - LEN_W'(1);
  assign mark_last_byte  = mark_last_frame[FRAME_W-1:3];
  assign lo_bit = (addr_r == base_r[FRAME_W-1:3]) ? base_r[2:0] : 3'd0;
  assign hi_bit = (addr_r == mark_last_byte) ? mark_last_frame[2:0] : 3'd7;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mark_mask[b] = (3'(b) >= lo_bit) && (3'(b) <= hi_bit);
    end
  end

  assign wr_en   = cmd.clr_step || cmd.mark_wr;
  assign wr_data = cmd.clr_step ? 8'h00 : ((mark_mask == FULL_BYTE) ? FULL_BYTE
                                                                    : (rdata_r | mark_mask));
  assign rd_en   = issue || cmd.mark_rd;

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[addr_r] <= wr_data;
    if (rd_en) rdata_r <= map_mem[addr_r];
  end

  assign mark_end = {1'b0, {1'b0, req_r.start_frame}} + {1'b0, req_r.run_length};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pages_r        <= PAGES_RESET;
      addr_r         <= '0;
      dv_r           <= 1'b0;
      issue_done_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) pages_r <= cfg_wr_data;

      if (cmd.clr_step || cmd.mark_wr || issue) begin
        addr_r <= addr_r + BYTE_IDX_W'(1);
      end else if (cmd.scan_start) begin
        addr_r <= '0;
      end else if (cmd.mark_init) begin
        addr_r <= base_r[FRAME_W-1:3];
      end

      if (cmd.scan_start) begin
        dv_r         <= 1'b0;
        issue_done_r <= 1'b0;
      end else if (cmd.scan_step) begin
        dv_r <= issue;
        if (issue && addr_r == scan_last_byte) issue_done_r <= 1'b1;
      end

      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) req_r <= in_data;
    if (cmd.scan_step) daddr_r <= addr_r;
    if (cmd.scan_start) cnt_r <= '0;
    else if (cmd.scan_step && dv_r) cnt_r <= cnt_v;
    if (cmd.base_from_start) base_r <= req_r.start_frame;
    else if (cmd.scan_step && dv_r && hit_v) base_r <= base_v;
    if (cmd.res_set) begin
      res_code_r     <= cmd.res_code;
      res_use_base_r <= cmd.res_use_base;
    end
    if (cmd.out_load) begin
      out_data_r.status        <= res_code_r;
      out_data_r.frame_address <= res_use_base_r ? (ADDR_W'(base_r) << PAGE_SHIFT) : '0;
    end
  end

  assign stat.clr_last   = (addr_r == LAST_MAP_IDX);
  assign stat.action     = req_r.action;
  assign stat.len_zero   = (req_r.run_length == '0);
  assign stat.mark_oob   = (mark_end > {1'b0, limit});
  assign stat.alloc_none = (limit == '0) || (req_r.run_length > limit);
  assign stat.scan_hit   = dv_r && hit_v;
  assign stat.scan_fail  = dv_r && !hit_v && (daddr_r == scan_last_byte);
  assign stat.mark_last  = (addr_r == mark_last_byte);
  assign stat.out_busy   = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/bitmap_frame_allocator_core.sv =====
// Top level of the bitmap frame allocator: controller plus datapath.
`timescale 1ns / 1ps

// First-fit page frame allocator over a bitmap of 4096 frames, one bit per frame, held in a
// 512 x 8 memory. After reset the block runs a clearing pass, one bitmap byte per cycle,
// during which it stalls the input; configuration writes are taken at any time.
// One transaction is worked on at a time, and the input is stalled from the cycle after a
// transaction is accepted until the block is back in idle. A rejected or zero-length
// request goes from accept through decide straight to posting the result.
// An allocate transaction scans the bitmap one byte per cycle: after decide it reads each
// byte up to the page count in turn and checks the last byte read, and it stops as soon as
// a free run of the requested length is found. The run is then marked by a setup step plus
// a read-modify-write of each bitmap byte it touches, followed by posting the result. A mark
// transaction goes through accept, decide and mark setup, a read-modify-write of each byte
// touched and posting the result. The scan rate is set by the single read port of the bitmap
// memory. A finished result sits in an output register, so a stalled result channel only
// holds the block once the next result is ready. A frame_address is the frame index times
// the 4096-byte page size; status is 0 for success, 1 for out of memory and 2 for a mark
// range past the configured page count. The page count saturates at 4096 where it is used;
// the register keeps the value written.

module bitmap_frame_allocator_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [bfa_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bfa_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bfa_pkg::out_item_t        out_data
);
  import bfa_pkg::*;

  // Command and status bundles between the controller and the datapath.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences the clearing pass, the search and the marking loop.
  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // The datapath owns the bitmap memory, the page count register and the result register.
  bfa_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

// ===== test/bitmap_frame_allocator_core_test.sv =====
// Self-checking testbench for the bitmap frame allocator core.
`timescale 1ns / 1ps

// The testbench keeps its own picture of the frame bitmap and the page count. Each request
// accepted on the input channel is run through that picture, and the reply it should produce
// is queued. Each reply accepted on the output channel is compared with the oldest queued one.
// The stimulus starts with a short directed sequence that covers the corners: zero-length
// requests, a page count of zero, a page count past capacity, runs that end exactly at the
// page count, re-marking, and out-of-memory. It then runs random phases, each under its own
// page count. The page count only changes while the block is idle, so the run drains every
// reply before each register write.
module bitmap_frame_allocator_core_test;
  import bfa_pkg::*;

  localparam int NUM_PHASES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  // Requests waiting for the driver, and the replies that requests already taken will produce.
  in_item_t request_queue[$];
  out_item_t reply_queue[$];

  // Shadow copy of the allocator state: one bit per frame (1 = used) and the page count.
  logic [MAX_FRAMES-1:0] used_frames = '0;
  logic [LEN_W-1:0] page_count = PAGES_RESET;

  // While this is set, neither side idles nor stalls.
  bit steady = 1'b0;

  int unsigned mismatches = 0;
  int unsigned requests_taken = 0;
  int unsigned replies_ok = 0;
  int unsigned replies_oom = 0;
  int unsigned replies_range = 0;
  int unsigned settings_used = 1;

  // The random phases mostly climb through the page counts, so frames that fill up under
  // a small count leave room higher up for larger counts. 8191 is past capacity and acts as 4096.
  int unsigned phase_pages [NUM_PHASES] = '{16, 100, 0, 333, 1000, 4096, 8191, 4095};
  int unsigned phase_items [NUM_PHASES] = '{150, 150, 40, 150, 250, 400, 200, 200};

  bitmap_frame_allocator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Runs one request against the shadow bitmap and returns the reply it must produce.
  // Allocation is first fit from frame 0, bounded by the page count.
  function automatic out_item_t serve_request(in_item_t req);
    int unsigned limit;
    int unsigned first;
    int unsigned count;
    int unsigned free_run;
    int unsigned base;
    int unsigned f;
    bit found;
    out_item_t reply;
    limit = (page_count > MAX_FRAMES) ? MAX_FRAMES : page_count;
    first = req.start_frame;
    count = req.run_length;
    reply.frame_address = '0;
    reply.status = STATUS_OK;
    if (req.action == ACTION_MARK) begin
      // A range that pokes past the page count is rejected whole; nothing gets marked.
      if (first + count > limit) begin
        reply.status = STATUS_RANGE;
      end else begin
        for (f = first; f < first + count; f++) used_frames[f] = 1'b1;
      end
    end else begin
      found = 1'b0;
      base = 0;
      if (limit > 0 && count <= limit) begin
        if (count == 0) begin
          // A zero-length allocation succeeds at frame 0 and marks nothing.
          found = 1'b1;
        end else begin
          free_run = 0;
          for (f = 0; f < limit && !found; f++) begin
            if (used_frames[f]) begin
              free_run = 0;
            end else begin
              free_run++;
              if (free_run == count) begin
                base = f + 1 - count;
                found = 1'b1;
              end
            end
          end
        end
      end
      if (found) begin
        for (f = base; f < base + count; f++) used_frames[f] = 1'b1;
        reply.frame_address = ADDR_W'(base * PAGE_BYTES);
      end else begin
        reply.status = STATUS_OOM;
      end
    end
    return reply;
  endfunction

  // Builds one random request for the current page count. Most are well-formed: small
  // allocations and marks that fit below the page count. The rest probe the edges and
  // throw in raw field values.
  function automatic in_item_t random_request();
    int unsigned limit;
    int unsigned pick;
    int unsigned count;
    in_item_t req;
    limit = (page_count > MAX_FRAMES) ? MAX_FRAMES : page_count;
    pick = $urandom_range(0, 99);
    req.action = ACTION_ALLOC;
    req.start_frame = FRAME_W'($urandom);
    req.run_length = '0;
    if (pick < 42) begin
      req.run_length = LEN_W'($urandom_range(1, 6));
    end else if (pick < 48) begin
      req.run_length = LEN_W'($urandom_range(7, 40));
    end else if (pick < 51) begin
      req.run_length = '0;
    end else if (pick < 54) begin
      req.run_length = LEN_W'($urandom);
    end else if (pick < 55) begin
      // Ask for the whole managed area at once.
      req.run_length = LEN_W'(limit);
    end else begin
      req.action = ACTION_MARK;
      if (pick < 88 && limit > 0) begin
        count = $urandom_range(0, (limit < 4) ? limit : 4);
        req.start_frame = FRAME_W'($urandom_range(0, limit - count));
        req.run_length = LEN_W'(count);
      end else if (pick < 94 && limit >= 8) begin
        // A run that ends right at the page count, or one frame past it.
        count = $urandom_range(1, 8);
        req.start_frame = FRAME_W'(limit - count + $urandom_range(0, 1));
        req.run_length = LEN_W'(count);
      end else begin
        req.run_length = LEN_W'($urandom);
      end
    end
    return req;
  endfunction

  task automatic queue_request(logic action, int unsigned first, int unsigned count);
    in_item_t req;
    req.action = action;
    req.start_frame = FRAME_W'(first);
    req.run_length = LEN_W'(count);
    request_queue.push_back(req);
  endtask

  // Returns once every queued request has been taken and every reply has come back.
  task automatic wait_for_idle();
    do @(posedge clk);
    while (request_queue.size() != 0 || in_valid || reply_queue.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // The block must be idle when this is called.
  task automatic write_page_count(int unsigned value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= LEN_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    page_count = LEN_W'(value);
    settings_used++;
  endtask

  // Input driver. A new transaction goes out only once the previous one has been taken,
  // and the sender idles now and then by leaving valid low.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        reply_queue.push_back(serve_request(in_data));
        requests_taken++;
      end
      if (request_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 11)) begin
        in_data <= request_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor. It checks each reply taken at this edge and picks the stall for the next.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (reply_queue.size() == 0) begin
          mismatches++;
          $display("%0t: reply with none pending: frame_address %h, status %0d",
                   $time, out_data.frame_address, out_data.status);
        end else begin
          want = reply_queue.pop_front();
          if (out_data.frame_address !== want.frame_address) begin
            mismatches++;
            $display("%0t: frame_address expected %h, actual %h",
                     $time, want.frame_address, out_data.frame_address);
          end
          if (out_data.status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d, actual %0d",
                     $time, want.status, out_data.status);
          end
          case (want.status)
            STATUS_OK:  replies_ok++;
            STATUS_OOM: replies_oom++;
            default:    replies_range++;
          endcase
        end
      end
      out_stall <= !steady && ($urandom_range(0, 99) < 11);
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners under the reset page count of 4096.
    queue_request(ACTION_ALLOC, 0, 0);          // zero-length allocation: frame 0, ok
    queue_request(ACTION_ALLOC, 4095, 1);       // frame 0
    queue_request(ACTION_ALLOC, 0, 3);          // frames 1 to 3
    queue_request(ACTION_MARK, 4095, 1);        // last frame, ends exactly at the count
    queue_request(ACTION_MARK, 4095, 2);        // one frame past the count
    queue_request(ACTION_MARK, 0, 0);           // zero-length mark
    queue_request(ACTION_MARK, 4095, 8191);     // both fields at their maximum
    queue_request(ACTION_MARK, 8, 8);           // one whole bitmap byte
    queue_request(ACTION_MARK, 21, 4);          // straddles a byte boundary
    queue_request(ACTION_ALLOC, 0, 4096);       // whole area, but some frames are used
    queue_request(ACTION_ALLOC, 0, 8191);       // longer than the page count
    queue_request(ACTION_ALLOC, 0, 5);          // skips the short hole at frames 4 to 7
    wait_for_idle();

    // With no frames managed even a zero-length allocation fails.
    write_page_count(0);
    queue_request(ACTION_ALLOC, 0, 0);
    queue_request(ACTION_MARK, 0, 0);
    queue_request(ACTION_MARK, 0, 1);
    queue_request(ACTION_ALLOC, 0, 1);
    queue_request(ACTION_MARK, 12'hAAA, 13'h1555);
    queue_request(ACTION_MARK, 12'h555, 13'h0AAA);
    wait_for_idle();

    // A count past capacity behaves as full capacity.
    write_page_count(8191);
    queue_request(ACTION_MARK, 4095, 1);
    queue_request(ACTION_ALLOC, 0, 4);          // fills the hole at frames 4 to 7
    wait_for_idle();

    // Allocations under a small page count, and marks that end right at it.
    write_page_count(30);
    queue_request(ACTION_ALLOC, 0, 2);
    queue_request(ACTION_ALLOC, 0, 1);
    queue_request(ACTION_MARK, 29, 1);          // marks the last frame, ends exactly at the count
    queue_request(ACTION_MARK, 30, 0);
    wait_for_idle();

    // Random phases. Each one drains completely before the page count changes.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_page_count(phase_pages[p]);
      steady = (p == 4);
      for (int i = 0; i < phase_items[p]; i++) request_queue.push_back(random_request());
      wait_for_idle();
    end
    steady = 1'b0;

    wait_for_idle();
    repeat (20) @(posedge clk);
    $display("Covered %0d requests over %0d page-count settings.",
             requests_taken, settings_used);
    $display("Replies: %0d ok, %0d out of memory, %0d range rejects.",
             replies_ok, replies_oom, replies_range);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every request a full scan and a full-width mark,
  // with both sides idling, plus the clearing pass after reset.
  initial begin
    #60ms;
    $display("Verification failed");
    $finish;
  end

endmodule
